FILE: rtl/fsa_pkg.sv
// ----------------------------------------------------------------------------
// fsa_pkg
// Types and constants shared by the scatter-add assembly block and its
// channel interfaces.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int VAL_W  = 48;
  localparam int IDX_W  = 6;
  localparam int MODE_W = 2;

  // Number of indices the fixed-width index fields can reach
  localparam int IDX_LIMIT = 1 << IDX_W;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [IDX_W-1:0]        index_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_MAT_ADD     = 2'd0,
    MODE_VEC_ADD     = 2'd1,
    MODE_VEC_GATHER  = 2'd2,
    MODE_ZERO_GATHER = 2'd3
  } mode_t;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_t;

  localparam value_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam value_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

endpackage

FILE: rtl/fsa_if.sv
// ----------------------------------------------------------------------------
// fsa_in_if / fsa_out_if
// Valid/ready channels for contribution beats and result beats.
// ----------------------------------------------------------------------------
interface fsa_in_if
  import fsa_pkg::*;
();
  logic   valid;
  logic   ready;
  mode_t  mode;
  index_t row_index;
  index_t col_index;
  value_t contribution;

  modport source (output valid, mode, row_index, col_index, contribution, input ready);
  modport sink   (input valid, mode, row_index, col_index, contribution, output ready);
endinterface

interface fsa_out_if
  import fsa_pkg::*;
();
  logic   valid;
  logic   ready;
  value_t result_value;
  logic   saturated;

  modport source (output valid, result_value, saturated, input ready);
  modport sink   (input valid, result_value, saturated, output ready);
endinterface

FILE: rtl/fem_scatter_add_assembly_unit.sv
// ----------------------------------------------------------------------------
// fem_scatter_add_assembly_unit
// Scatter-add of local contributions into a global matrix store and vector
// store, with saturating Q23.24 accumulation and vector gather.
//
//   channel   modport   payload
//   contrib   sink      mode, row_index, col_index, contribution
//   result    source    result_value, saturated
//
// One beat per cycle when result is not stalled: read on accept; add, write
// back and register the result as the add stage advances; forward write data
// to a following beat. Results are registered after the add stage.
// After reset a clearing pass zeroes both stores, one matrix entry per cycle
// over all NV*NV entries; contrib is not ready during it.
// A stalled result holds the beat in the add stage and blocks contrib.
// ----------------------------------------------------------------------------
module fem_scatter_add_assembly_unit
  import fsa_pkg::*;
#(
  parameter int VAR_COUNT = 64
) (
  input logic       clk,
  input logic       rst,
  fsa_in_if.sink    contrib,
  fsa_out_if.source result
);

  // Rows and columns reachable through the index fields
  localparam int NV        = (VAR_COUNT < IDX_LIMIT) ? VAR_COUNT : IDX_LIMIT;
  localparam int MAT_DEPTH = NV * NV;
  localparam int VA_W      = $clog2(NV);
  localparam int MA_W      = $clog2(MAT_DEPTH);

  value_t mat_mem [MAT_DEPTH];
  value_t vec_mem [NV];

  state_t state, state_next;
  logic   clearing, running;

  logic [MA_W-1:0] clr_addr;
  logic            clr_last;

  // Add stage registers
  logic            busy;
  mode_t           st_mode;
  logic            st_ok;
  logic [MA_W-1:0] st_maddr;
  logic [VA_W-1:0] st_vaddr;
  value_t          st_contrib;

  value_t mat_rd, vec_rd;
  logic   fwd_mat, fwd_vec;
  value_t fwd_data;

  value_t out_value;
  logic   out_sat;
  logic   out_valid;

  logic            accept, advance, ready;
  logic [MA_W-1:0] in_maddr;
  logic [VA_W-1:0] in_vaddr;
  logic            in_ok;

  value_t            base;
  logic [VAL_W:0]    sum;
  logic              ovf;
  value_t            sum_sat;
  value_t            res_value;
  logic              res_sat;
  logic              wr_mat, wr_vec;
  logic              mat_we, vec_we;
  logic [MA_W-1:0]   mat_waddr;
  logic [VA_W-1:0]   vec_waddr;
  value_t            wdata;

  // ---------------------------------------------------------------- control
  assign clr_last = (clr_addr == MA_W'(MAT_DEPTH - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_last) state_next = ST_RUN;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    clearing = 1'b0;
    running  = 1'b0;
    case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   running  = 1'b1;
      default:  clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing && !clr_last) clr_addr <= clr_addr + MA_W'(1);
    end
  end

  assign advance = busy && (!out_valid || result.ready);
  assign ready   = running && (!busy || advance);
  assign accept  = contrib.valid && ready;

  assign contrib.ready = ready;

  // ---------------------------------------------------------- address decode
  assign in_maddr = MA_W'(MA_W'(contrib.row_index) * MA_W'(NV) + MA_W'(contrib.col_index));
  assign in_vaddr = contrib.row_index[VA_W-1:0];

  always_comb begin
    in_ok = 1'b0;
    case (contrib.mode)
      MODE_MAT_ADD: in_ok = (32'(contrib.row_index) < NV) && (32'(contrib.col_index) < NV);
      MODE_VEC_ADD, MODE_VEC_GATHER: in_ok = (32'(contrib.row_index) < NV);
      default: in_ok = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------- add stage
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (advance) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_mode    <= contrib.mode;
      st_ok      <= in_ok;
      st_maddr   <= in_maddr;
      st_vaddr   <= in_vaddr;
      st_contrib <= contrib.contribution;
      // Catch a read of the entry being written back this same cycle
      fwd_mat    <= wr_mat && (in_maddr == st_maddr);
      fwd_vec    <= wr_vec && (in_vaddr == st_vaddr);
      fwd_data   <= sum_sat;
    end
  end

  always_comb begin
    if (st_mode == MODE_MAT_ADD) base = fwd_mat ? fwd_data : mat_rd;
    else                         base = fwd_vec ? fwd_data : vec_rd;
  end

  assign sum     = {base[VAL_W-1], base} + {st_contrib[VAL_W-1], st_contrib};
  assign ovf     = (sum[VAL_W] != sum[VAL_W-1]);
  assign sum_sat = ovf ? (sum[VAL_W] ? VAL_MIN : VAL_MAX) : value_t'(sum[VAL_W-1:0]);

  always_comb begin
    res_value = '0;
    res_sat   = 1'b0;
    case (st_mode)
      MODE_MAT_ADD, MODE_VEC_ADD: begin
        if (st_ok) begin
          res_value = sum_sat;
          res_sat   = ovf;
        end
      end
      MODE_VEC_GATHER: if (st_ok) res_value = base;
      default: res_value = '0;
    endcase
  end

  assign wr_mat = advance && st_ok && (st_mode == MODE_MAT_ADD);
  assign wr_vec = advance && st_ok && (st_mode == MODE_VEC_ADD);

  // ---------------------------------------------------------------- memories
  assign mat_we    = clearing || wr_mat;
  assign mat_waddr = clearing ? clr_addr : st_maddr;
  assign vec_we    = (clearing && (32'(clr_addr) < NV)) || wr_vec;
  assign vec_waddr = clearing ? clr_addr[VA_W-1:0] : st_vaddr;
  assign wdata     = clearing ? value_t'(0) : sum_sat;

  always_ff @(posedge clk) begin
    if (mat_we) mat_mem[mat_waddr] <= wdata;
    if (accept) mat_rd <= mat_mem[in_maddr];
  end

  always_ff @(posedge clk) begin
    if (vec_we) vec_mem[vec_waddr] <= wdata;
    if (accept) vec_rd <= vec_mem[in_vaddr];
  end

  // ---------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value <= res_value;
      out_sat   <= res_sat;
    end
  end

  assign result.valid        = out_valid;
  assign result.result_value = out_value;
  assign result.saturated    = out_sat;

endmodule

FILE: bench/fsa_assembly_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsa_assembly_checker
// Watches the contribution and result channels of the scatter-add assembly
// unit, keeps a shadow copy of the matrix and vector stores, and compares
// every result beat in order with the value its contribution should produce.
// ----------------------------------------------------------------------------
module fsa_assembly_checker
  import fsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  fsa_in_if    contrib,
  fsa_out_if   result,
  output int   fail_count,
  output int   outstanding
);

  typedef struct packed {
    value_t value;
    logic   saturated;
  } entry_sum_t;

  value_t     matrix_sums [IDX_LIMIT][IDX_LIMIT];
  value_t     vector_sums [IDX_LIMIT];
  entry_sum_t entry_sums_q[$];

  // Add in 49 bits, clamp on overflow
  function automatic entry_sum_t saturating_sum(input value_t base, input value_t addend);
    logic [VAL_W:0] wide;
    entry_sum_t     s;
    wide = {base[VAL_W-1], base} + {addend[VAL_W-1], addend};
    s.saturated = wide[VAL_W] != wide[VAL_W-1];
    if (!s.saturated) begin
      s.value = wide[VAL_W-1:0];
    end else if (wide[VAL_W]) begin
      s.value = VAL_MIN;
    end else begin
      s.value = VAL_MAX;
    end
    return s;
  endfunction

  always @(posedge clk) begin : track
    entry_sum_t predicted;
    if (rst) begin
      for (int r = 0; r < IDX_LIMIT; r++) begin
        vector_sums[r] = '0;
        for (int c = 0; c < IDX_LIMIT; c++) begin
          matrix_sums[r][c] = '0;
        end
      end
      entry_sums_q.delete();
    end else begin
      // Retire the result beat first: it always belongs to an earlier contribution
      if (result.valid && result.ready) begin
        if (entry_sums_q.size() == 0) begin
          $error("result beat with no contribution pending: result_value %0d, saturated %0b",
                 result.result_value, result.saturated);
          fail_count++;
        end else begin
          predicted = entry_sums_q.pop_front();
          if (result.result_value !== predicted.value) begin
            $error("result_value: expected %0d, got %0d", predicted.value,
                   result.result_value);
            fail_count++;
          end
          if (result.saturated !== predicted.saturated) begin
            $error("saturated: expected %0b, got %0b", predicted.saturated, result.saturated);
            fail_count++;
          end
        end
      end
      if (contrib.valid && contrib.ready) begin
        predicted.value     = '0;
        predicted.saturated = 1'b0;
        case (contrib.mode)
          MODE_MAT_ADD: begin
            predicted = saturating_sum(matrix_sums[contrib.row_index][contrib.col_index],
                                       contrib.contribution);
            matrix_sums[contrib.row_index][contrib.col_index] = predicted.value;
          end
          MODE_VEC_ADD: begin
            predicted = saturating_sum(vector_sums[contrib.row_index], contrib.contribution);
            vector_sums[contrib.row_index] = predicted.value;
          end
          MODE_VEC_GATHER: begin
            predicted.value = vector_sums[contrib.row_index];
          end
          default: begin
            // zero gather: leave the result at zero
          end
        endcase
        entry_sums_q.push_back(predicted);
      end
    end
    outstanding <= entry_sums_q.size();
  end

endmodule

FILE: bench/tb_fem_scatter_add_assembly_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fem_scatter_add_assembly_unit
// Drives contribution beats into the scatter-add assembly unit: a directed
// set of corner cases, then random matrix/vector adds and gathers on a hot
// set of entries, under three idling profiles on both channels. The checker
// beside the unit predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_fem_scatter_add_assembly_unit;
  import fsa_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_BEATS = 700;
  localparam int TAIL_CYCLES  = 8;

  logic clk = 1'b0;
  logic rst;
  int   src_idle_pct  = 0;
  int   sink_idle_pct = 0;
  int   quiet_cycles  = 0;
  int   fail_count;
  int   outstanding;

  fsa_in_if  contrib_ch ();
  fsa_out_if result_ch ();

  fem_scatter_add_assembly_unit dut (
    .clk     (clk),
    .rst     (rst),
    .contrib (contrib_ch),
    .result  (result_ch)
  );

  fsa_assembly_checker assembly_check (
    .clk         (clk),
    .rst         (rst),
    .contrib     (contrib_ch),
    .result      (result_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // End the run if no beat moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (contrib_ch.valid && contrib_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_fem_scatter_add_assembly_unit: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Returns at the edge where the beat is accepted, valid still high
  task automatic send_beat(input mode_t m, input index_t r, input index_t c, input value_t v);
    while ($urandom_range(99) < src_idle_pct) begin
      contrib_ch.valid <= 1'b0;
      @(posedge clk);
    end
    contrib_ch.valid        <= 1'b1;
    contrib_ch.mode         <= m;
    contrib_ch.row_index    <= r;
    contrib_ch.col_index    <= c;
    contrib_ch.contribution <= v;
    do @(posedge clk); while (!contrib_ch.ready);
  endtask

  // Hold the sender off until every pending result has come back
  task automatic wait_drained();
    contrib_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Half the beats hit a few hot entries so sums build up and forwarding is hit
  function automatic index_t pick_index();
    if ($urandom_range(1) == 1) begin
      return index_t'($urandom_range(3));
    end
    return index_t'($urandom_range(IDX_LIMIT - 1));
  endfunction

  function automatic value_t pick_contribution();
    int unsigned sel;
    int          near;
    sel  = $urandom_range(9);
    near = $urandom;
    if (sel < 4) begin
      return value_t'({$urandom, $urandom});
    end else if (sel == 4) begin
      case ($urandom_range(3))
        0:       return VAL_MAX;
        1:       return VAL_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    return value_t'(near);
  endfunction

  task automatic run_random(input int beats);
    for (int i = 0; i < beats; i++) begin
      send_beat(mode_t'($urandom_range(3)), pick_index(), pick_index(), pick_contribution());
    end
  endtask

  initial begin
    rst                     <= 1'b1;
    contrib_ch.valid        <= 1'b0;
    contrib_ch.mode         <= MODE_MAT_ADD;
    contrib_ch.row_index    <= '0;
    contrib_ch.col_index    <= '0;
    contrib_ch.contribution <= '0;
    src_idle_pct  = 6;
    sink_idle_pct = 53;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Saturate one matrix entry high and pull it back into range, saturate another low
    send_beat(MODE_MAT_ADD, 6'd0, 6'd0, VAL_MAX);
    send_beat(MODE_MAT_ADD, 6'd0, 6'd0, value_t'(1));
    send_beat(MODE_MAT_ADD, 6'd0, 6'd0, VAL_MIN);
    send_beat(MODE_MAT_ADD, 6'd63, 6'd63, VAL_MIN);
    send_beat(MODE_MAT_ADD, 6'd63, 6'd63, value_t'(-1));
    send_beat(MODE_MAT_ADD, 6'd63, 6'd0, value_t'(48'sh0000_0180_0000));
    send_beat(MODE_MAT_ADD, 6'd0, 6'd63, value_t'(-48'sh0000_0080_0000));
    send_beat(MODE_MAT_ADD, 6'd0, 6'd63, '0);
    // Vector entries at both ends, saturating on the second add
    send_beat(MODE_VEC_ADD, 6'd63, 6'd0, VAL_MAX);
    send_beat(MODE_VEC_ADD, 6'd63, 6'd0, VAL_MAX);
    send_beat(MODE_VEC_ADD, 6'd0, 6'd63, VAL_MIN);
    send_beat(MODE_VEC_ADD, 6'd0, 6'd63, VAL_MIN);
    // Column is ignored outside matrix mode
    send_beat(MODE_VEC_ADD, 6'd7, 6'd63, value_t'(1));
    send_beat(MODE_VEC_GATHER, 6'd7, 6'd0, VAL_MIN);
    send_beat(MODE_VEC_GATHER, 6'd63, 6'd63, '0);
    send_beat(MODE_VEC_GATHER, 6'd0, 6'd0, VAL_MAX);
    send_beat(MODE_VEC_GATHER, 6'd5, 6'd9, '1);
    // Zero gather returns zero whatever the fields hold
    send_beat(MODE_ZERO_GATHER, 6'd63, 6'd63, VAL_MAX);
    send_beat(MODE_ZERO_GATHER, 6'd0, 6'd0, VAL_MIN);
    // Add then gather the same entry back to back
    send_beat(MODE_VEC_ADD, 6'd0, 6'd0, VAL_MAX);
    send_beat(MODE_VEC_GATHER, 6'd0, 6'd0, '0);

    run_random(RANDOM_BEATS);
    wait_drained();

    src_idle_pct  = 53;
    sink_idle_pct = 6;
    run_random(RANDOM_BEATS);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(RANDOM_BEATS);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_fem_scatter_add_assembly_unit: PASS");
    end else begin
      $display("tb_fem_scatter_add_assembly_unit: FAIL");
    end
    $finish;
  end

endmodule

FILE: fem_scatter_add_assembly_unit.f
rtl/fsa_pkg.sv
rtl/fsa_if.sv
rtl/fem_scatter_add_assembly_unit.sv
bench/fsa_assembly_checker.sv
bench/tb_fem_scatter_add_assembly_unit.sv
